FILE: hdl/twuc_pkg.sv
// Shared types and constants for the turret wrap/unwind controller.
package twuc_pkg;

    localparam int ANGLE_W  = 15;
    localparam int ERROR_W  = 16;
    localparam int EFFORT_W = 8;
    localparam int LIMIT_W  = 14;
    localparam int GAIN_W   = 16;
    localparam int TARGET_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    // working width for angle sums and differences
    localparam int CMP_W    = 18;

    localparam logic signed [CMP_W-1:0] Q_PI   = 18'sd12868;
    localparam logic signed [CMP_W-1:0] Q_SEAM = 18'sd12288;

    localparam logic signed [EFFORT_W-1:0] EFF_MAX = 8'sd100;
    localparam logic signed [EFFORT_W-1:0] EFF_MIN = -8'sd100;

    localparam logic [LIMIT_W-1:0] WRAP_LIMIT_RST  = 14'd2048;
    localparam logic [LIMIT_W-1:0] TURN_BUFFER_RST = 14'd1024;
    localparam logic [GAIN_W-1:0]  GAIN_RST        = 16'd256;

    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_BUFFER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd2;

    typedef struct packed {
        logic [LIMIT_W-1:0] wrap_limit;
        logic [LIMIT_W-1:0] turn_buffer;
        logic [GAIN_W-1:0]  gain;
    } t_cfg;

endpackage

FILE: hdl/turret_wrap_unwind_controller_top.sv
// Top level: request and result registers, configuration registers, control core.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_angle_sample, i_track_error, i_enable
//  result   | o_out_valid / i_out_ready  | o_effort, o_unwinding
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while results are taken. A request is captured in the
// request register, worked through the gain multiply and loaded into the result register
// once that register is free. Synchronous active-low reset clears the valid flags and all
// control state but the unwind-active flag, which it sets, and loads the register
// defaults. A stalled result holds; the request register takes one more request, then
// input ready drops until the result is taken.
module turret_wrap_unwind_controller_top
    import twuc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [ANGLE_W-1:0]  i_angle_sample,
    input  logic signed [ERROR_W-1:0]  i_track_error,
    input  logic                       i_enable,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [EFFORT_W-1:0] o_effort,
    output logic                       o_unwinding,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cfg                       r_cfg;
    logic                       r_in_vld;
    logic signed [ANGLE_W-1:0]  r_angle;
    logic signed [ERROR_W-1:0]  r_error;
    logic                       r_enable;
    logic                       r_out_vld;
    logic signed [EFFORT_W-1:0] r_effort;
    logic                       r_unwinding;

    logic                       out_free, step;
    logic signed [EFFORT_W-1:0] core_effort;
    logic                       core_unwinding;

    assign out_free    = !r_out_vld || i_out_ready;
    assign step        = r_in_vld && out_free;
    assign o_in_ready  = !r_in_vld || step;
    assign o_out_valid = r_out_vld;
    assign o_effort    = r_effort;
    assign o_unwinding = r_unwinding;

    twuc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_angle     (r_angle),
        .i_error     (r_error),
        .i_enable    (r_enable),
        .i_cfg       (r_cfg),
        .o_effort    (core_effort),
        .o_unwinding (core_unwinding)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_limit  <= WRAP_LIMIT_RST;
            r_cfg.turn_buffer <= TURN_BUFFER_RST;
            r_cfg.gain        <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WRAP_LIMIT:  r_cfg.wrap_limit  <= i_cfg_data[LIMIT_W-1:0];
                REG_TURN_BUFFER: r_cfg.turn_buffer <= i_cfg_data[LIMIT_W-1:0];
                REG_GAIN:        r_cfg.gain        <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // capture the request payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_angle  <= i_angle_sample;
            r_error  <= i_track_error;
            r_enable <= i_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_effort    <= core_effort;
            r_unwinding <= core_unwinding;
        end
    end

endmodule

FILE: hdl/twuc_prop.sv
// Proportional effort: error times Q8.8 gain, truncated toward zero, clamped.
module twuc_prop
    import twuc_pkg::*;
(
    input  logic signed [ERROR_W-1:0]  i_error,
    input  logic [GAIN_W-1:0]          i_gain,
    output logic signed [EFFORT_W-1:0] o_effort
);

    logic signed [ERROR_W:0] err_w;
    logic [ERROR_W-1:0]      mag;
    logic [ERROR_W+GAIN_W-1:0] prod;
    logic [11:0]             quot;
    logic [EFFORT_W-1:0]     clamped;

    always_comb begin
        err_w = {i_error[ERROR_W-1], i_error};
        mag   = i_error[ERROR_W-1] ? ERROR_W'(-err_w) : ERROR_W'(err_w);
        prod  = mag * i_gain;
        // drop the 8 gain fraction bits and the 12 angle fraction bits
        quot  = prod[ERROR_W+GAIN_W-1:20];
        if (quot > 12'(EFF_MAX)) begin
            clamped = EFF_MAX;
        end else begin
            clamped = quot[EFFORT_W-1:0];
        end
        o_effort = i_error[ERROR_W-1] ? -$signed(clamped) : $signed(clamped);
    end

endmodule

FILE: hdl/twuc_core.sv
// Wrap tracking, unwind sequencing and effort selection, with the controller state.
module twuc_core
    import twuc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic signed [ANGLE_W-1:0]  i_angle,
    input  logic signed [ERROR_W-1:0]  i_error,
    input  logic                       i_enable,
    input  t_cfg                       i_cfg,
    output logic signed [EFFORT_W-1:0] o_effort,
    output logic                       o_unwinding
);

    logic                       r_wrap, n_wrap;
    logic                       r_pend, n_pend;
    logic                       r_cw, n_cw;
    logic                       r_active, n_active;
    logic signed [TARGET_W-1:0] r_target, n_target;
    logic signed [ANGLE_W-1:0]  r_prev;
    logic signed [EFFORT_W-1:0] r_held, n_held;

    logic signed [EFFORT_W-1:0] prop_eff;
    logic signed [CMP_W-1:0]    ang, prev, absang, band, buf_w, tgt;
    logic                       seam_cross, wrap1, arm, pend1;

    twuc_prop u_prop (
        .i_error  (i_error),
        .i_gain   (i_cfg.gain),
        .o_effort (prop_eff)
    );

    always_comb begin
        ang    = CMP_W'(i_angle);
        prev   = CMP_W'(r_prev);
        buf_w  = $signed({{(CMP_W-LIMIT_W){1'b0}}, i_cfg.turn_buffer});
        band   = Q_PI - $signed({{(CMP_W-LIMIT_W){1'b0}}, i_cfg.wrap_limit});
        absang = (ang < 0) ? -ang : ang;
        seam_cross = (ang > Q_SEAM && prev < -Q_SEAM) ||
                     (ang < -Q_SEAM && prev > Q_SEAM);
        wrap1  = r_wrap ^ seam_cross;
        arm    = !r_active && wrap1 && (absang < band);
        pend1  = r_pend || arm;

        n_wrap   = r_wrap;
        n_pend   = r_pend;
        n_cw     = r_cw;
        n_active = r_active;
        n_target = r_target;
        o_effort = '0;

        if (i_enable) begin
            n_wrap = wrap1;
            n_pend = pend1;
            if (arm && ang < 0) begin
                n_target = TARGET_W'(ang + buf_w);
            end else if (arm && ang > 0) begin
                n_target = TARGET_W'(ang - buf_w);
            end
            tgt = CMP_W'(n_target);

            if (pend1) begin
                // hold the last effort while the direction is chosen
                o_effort = r_held;
                if (ang != 0) begin
                    n_cw     = (ang > 0);
                    n_pend   = 1'b0;
                    n_active = 1'b1;
                end
            end else if (r_cw && r_active) begin
                o_effort = EFF_MIN;
                if (ang < tgt && ang > tgt - buf_w) begin
                    n_active = 1'b0;
                    n_wrap   = 1'b0;
                end
            end else if (!r_cw && r_active) begin
                o_effort = EFF_MAX;
                if (ang > tgt && ang < tgt + buf_w) begin
                    n_active = 1'b0;
                    n_wrap   = 1'b0;
                end
            end else begin
                o_effort = prop_eff;
            end
        end else begin
            tgt = CMP_W'(r_target);
        end

        n_held      = o_effort;
        o_unwinding = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap   <= 1'b0;
            r_pend   <= 1'b0;
            r_cw     <= 1'b0;
            r_active <= 1'b1;
            r_target <= '0;
            r_prev   <= '0;
            r_held   <= '0;
        end else if (i_step) begin
            r_wrap   <= n_wrap;
            r_pend   <= n_pend;
            r_cw     <= n_cw;
            r_active <= n_active;
            r_target <= n_target;
            r_prev   <= i_angle;
            r_held   <= n_held;
        end
    end

endmodule
